// ===== design/quoted_escape_encoder_defines.svh =====
// Assertion macros for the quoted escape encoder, used by the serializer.
`ifndef QUOTED_ESCAPE_ENCODER_DEFINES_SVH
`define QUOTED_ESCAPE_ENCODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define QEE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define QEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QEE_ASSERT_SAME(label, ante, cons, msg)
`define QEE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== design/qee_pkg.sv =====
// Types, character constants and helpers of the quoted escape encoder.
`timescale 1ns / 1ps
package qee_pkg;

  localparam int unsigned RUN_MAX = 6;
  localparam int unsigned LEN_W   = 3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  typedef struct packed {
    logic       empty_string;
    logic       first_of_string;
    logic       last_of_string;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_run;
    logic       end_of_text;
  } slot_t;

  typedef struct packed {
    slot_t [RUN_MAX-1:0] slots;
    logic  [LEN_W-1:0]   len;
  } run_t;

  // Lowercase hex digit for one nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'd10) ? (8'h30 + wide) : (8'h57 + wide);
  endfunction

endpackage

// ===== design/qee_decode.sv =====
// Translates one input word into its run of quoted, escaped characters.
`timescale 1ns / 1ps
module qee_decode (
  input  qee_pkg::item_t item,
  output qee_pkg::run_t  run
);

  logic [7:0]                code;
  logic [7:0]                esc [4];
  logic [qee_pkg::LEN_W-1:0] n;
  logic [qee_pkg::LEN_W-1:0] pos;
  logic [qee_pkg::LEN_W-1:0] at;

  always_comb begin
    unique case (item.byte_value)
      qee_pkg::CH_BSLASH: code = qee_pkg::CH_BSLASH;
      qee_pkg::CH_QUOTE:  code = qee_pkg::CH_QUOTE;
      qee_pkg::CH_LF:     code = qee_pkg::CH_N;
      qee_pkg::CH_CR:     code = qee_pkg::CH_R;
      qee_pkg::CH_TAB:    code = qee_pkg::CH_T;
      qee_pkg::CH_BEL:    code = qee_pkg::CH_A;
      qee_pkg::CH_BS:     code = qee_pkg::CH_B;
      default:            code = 8'h00;
    endcase
  end

  always_comb begin
    esc[0] = qee_pkg::CH_BSLASH;
    esc[1] = code;
    esc[2] = qee_pkg::hex_digit(item.byte_value[7:4]);
    esc[3] = qee_pkg::hex_digit(item.byte_value[3:0]);
    n      = 3'd2;
    if (code == 8'h00) begin
      if (item.byte_value >= qee_pkg::CH_SPACE && item.byte_value <= qee_pkg::CH_TILDE) begin
        esc[0] = item.byte_value;
        n      = 3'd1;
      end else begin
        esc[1] = qee_pkg::CH_X;
        n      = 3'd4;
      end
    end
  end

  always_comb begin
    run = '0;
    pos = item.first_of_string ? 3'd1 : 3'd0;
    at  = '0;
    if (item.empty_string) begin
      run.slots[0].ch = qee_pkg::CH_QUOTE;
      run.slots[1]    = '{ch: qee_pkg::CH_QUOTE, end_of_run: 1'b1, end_of_text: 1'b1};
      run.len         = 3'd2;
    end else begin
      if (item.first_of_string) begin
        run.slots[0].ch = qee_pkg::CH_QUOTE;
      end
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < n) begin
          at                 = pos + 3'(i);
          run.slots[at].ch   = esc[i];
        end
      end
      if (item.last_of_string) begin
        run.slots[pos + n] = '{ch: qee_pkg::CH_QUOTE, end_of_run: 1'b1, end_of_text: 1'b1};
        run.len            = pos + n + 3'd1;
      end else begin
        run.slots[pos + n - 3'd1].end_of_run = 1'b1;
        run.len                              = pos + n;
      end
    end
  end

endmodule

// ===== design/qee_serializer.sv =====
// Holds one decoded run and sends its characters out one per cycle while the output is not stalled.
`timescale 1ns / 1ps
`include "quoted_escape_encoder_defines.svh"
module qee_serializer (
  input  logic          clk,
  input  logic          rst,
  input  logic          run_valid,
  input  qee_pkg::run_t run_in,
  output logic          take,
  output logic          char_valid,
  input  logic          char_stall,
  output logic [7:0]    out_char,
  output logic          end_of_run,
  output logic          end_of_text
);

  logic                      busy;
  qee_pkg::run_t             run;
  logic [qee_pkg::LEN_W-1:0] idx;
  logic                      out_free;
  logic                      emit;
  logic                      at_last;

  assign out_free = !char_valid || !char_stall;
  assign emit     = busy && out_free;
  assign at_last  = (idx == run.len - 3'd1);
  assign take     = !busy || (emit && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      idx        <= '0;
      char_valid <= 1'b0;
    end else begin
      if (take) begin
        busy <= run_valid;
        idx  <= '0;
      end else if (emit) begin
        idx <= idx + 3'd1;
      end
      if (out_free) begin
        char_valid <= busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && run_valid) begin
      run <= run_in;
    end
    if (emit) begin
      out_char    <= run.slots[idx].ch;
      end_of_run  <= run.slots[idx].end_of_run;
      end_of_text <= run.slots[idx].end_of_text;
    end
  end

  `QEE_ASSERT_SAME(a_idx_in_run, busy, idx < run.len, "character index beyond run length")
  `QEE_ASSERT_SAME(a_len_range, busy, run.len != 3'd0 && run.len <= 3'd6, "run length out of range")
  `QEE_ASSERT_SAME(a_text_is_quote, char_valid && end_of_text,
                   out_char == qee_pkg::CH_QUOTE && end_of_run, "end of text not on a quote")
  `QEE_ASSERT_NEXT(a_hold_idx, busy && !out_free, $stable(idx), "index moved while output stalled")

endmodule

// ===== design/quoted_escape_encoder.sv =====
// Top level of the quoted escape encoder: input register, decoder and serializer.
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// byte      byte_valid / byte_stall   byte_value, first_of_string, last_of_string, empty_string
// char      char_valid / char_stall   out_char, end_of_run, end_of_text
//
// One word produces 1 to 6 characters (4 for a hex escape, plus 1 per quote),
// sent one per cycle from the output register while char_stall is low.
// The input register takes the next word while the current run drains, and a
// new run starts in the cycle after the last character of the previous one.
// Reset (rst, synchronous) empties the input register, run buffer and output.
// A stall on the char side holds the output and backs up to byte_stall.

module quoted_escape_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] byte_value,
  input  logic       first_of_string,
  input  logic       last_of_string,
  input  logic       empty_string,
  output logic       char_valid,
  input  logic       char_stall,
  output logic [7:0] out_char,
  output logic       end_of_run,
  output logic       end_of_text
);

  // Input register: holds one word until the serializer can take its run.
  logic           held;
  qee_pkg::item_t item;
  qee_pkg::run_t  run;
  logic           take;
  logic           accept;

  // The register frees whenever the serializer takes the held word.
  assign byte_stall = held && !take;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= accept || (held && !take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= '{empty_string: empty_string, first_of_string: first_of_string,
                last_of_string: last_of_string, byte_value: byte_value};
    end
  end

  // Short translation from the held word to its run of characters.
  qee_decode u_decode (
    .item (item),
    .run  (run)
  );

  // Run buffer and output register.
  qee_serializer u_serializer (
    .clk         (clk),
    .rst         (rst),
    .run_valid   (held),
    .run_in      (run),
    .take        (take),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .out_char    (out_char),
    .end_of_run  (end_of_run),
    .end_of_text (end_of_text)
  );

endmodule

// ===== test/quoted_escape_encoder_checker.sv =====
// Scoreboard for the quoted escape encoder: predicts the escaped characters and checks them.
`timescale 1ns / 1ps
module quoted_escape_encoder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_stall,
  input  logic [7:0]  byte_value,
  input  logic        first_of_string,
  input  logic        last_of_string,
  input  logic        empty_string,
  input  logic        char_valid,
  input  logic        char_stall,
  input  logic [7:0]  out_char,
  input  logic        end_of_run,
  input  logic        end_of_text,
  output int unsigned pending,
  output int unsigned fail_count
);

  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_TEN  = 8'h61;

  qee_pkg::slot_t escaped_chars_q[$];
  int unsigned    mismatch_count = 0;

  assign fail_count = mismatch_count;

  function automatic qee_pkg::slot_t char_entry(input logic [7:0] ch, input logic eor,
                                                input logic eot);
    qee_pkg::slot_t s;
    s.ch          = ch;
    s.end_of_run  = eor;
    s.end_of_text = eot;
    return s;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return DIGIT_ZERO + {4'h0, nib};
    end
    return DIGIT_TEN + {4'h0, nib} - 8'd10;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("%0t ns checker: %s", $time, msg);
    mismatch_count++;
  endtask

  // Expands one accepted word into the characters the encoder must emit.
  task automatic encode_word(input qee_pkg::item_t w);
    logic [7:0] body [4];
    logic [7:0] code;
    int         n;
    if (w.empty_string) begin
      escaped_chars_q.push_back(char_entry(qee_pkg::CH_QUOTE, 1'b0, 1'b0));
      escaped_chars_q.push_back(char_entry(qee_pkg::CH_QUOTE, 1'b1, 1'b1));
      return;
    end
    if (w.first_of_string) begin
      escaped_chars_q.push_back(char_entry(qee_pkg::CH_QUOTE, 1'b0, 1'b0));
    end
    code = 8'h00;
    case (w.byte_value)
      qee_pkg::CH_BSLASH: code = qee_pkg::CH_BSLASH;
      qee_pkg::CH_QUOTE:  code = qee_pkg::CH_QUOTE;
      qee_pkg::CH_LF:     code = qee_pkg::CH_N;
      qee_pkg::CH_CR:     code = qee_pkg::CH_R;
      qee_pkg::CH_TAB:    code = qee_pkg::CH_T;
      qee_pkg::CH_BEL:    code = qee_pkg::CH_A;
      qee_pkg::CH_BS:     code = qee_pkg::CH_B;
      default:            code = 8'h00;
    endcase
    if (code != 8'h00) begin
      body[0] = qee_pkg::CH_BSLASH;
      body[1] = code;
      n = 2;
    end else if (w.byte_value >= qee_pkg::CH_SPACE && w.byte_value <= qee_pkg::CH_TILDE) begin
      body[0] = w.byte_value;
      n = 1;
    end else begin
      body[0] = qee_pkg::CH_BSLASH;
      body[1] = qee_pkg::CH_X;
      body[2] = hex_char(w.byte_value[7:4]);
      body[3] = hex_char(w.byte_value[3:0]);
      n = 4;
    end
    for (int i = 0; i < n; i++) begin
      escaped_chars_q.push_back(char_entry(body[i], !w.last_of_string && (i == n - 1), 1'b0));
    end
    if (w.last_of_string) begin
      escaped_chars_q.push_back(char_entry(qee_pkg::CH_QUOTE, 1'b1, 1'b1));
    end
  endtask

  always @(posedge clk) begin
    qee_pkg::slot_t want;
    qee_pkg::item_t got_word;
    if (!rst) begin
      if (char_valid && !char_stall) begin
        if (escaped_chars_q.size() == 0) begin
          note_mismatch($sformatf("char 0x%02h arrived with nothing expected", out_char));
        end else begin
          want = escaped_chars_q.pop_front();
          if (out_char !== want.ch) begin
            note_mismatch($sformatf("out_char 0x%02h, expected 0x%02h", out_char, want.ch));
          end
          if (end_of_run !== want.end_of_run) begin
            note_mismatch($sformatf("end_of_run %b, expected %b on char 0x%02h",
                                    end_of_run, want.end_of_run, want.ch));
          end
          if (end_of_text !== want.end_of_text) begin
            note_mismatch($sformatf("end_of_text %b, expected %b on char 0x%02h",
                                    end_of_text, want.end_of_text, want.ch));
          end
        end
      end
      if (byte_valid && !byte_stall) begin
        got_word.empty_string    = empty_string;
        got_word.first_of_string = first_of_string;
        got_word.last_of_string  = last_of_string;
        got_word.byte_value      = byte_value;
        encode_word(got_word);
      end
    end
    pending = escaped_chars_q.size();
  end

endmodule

// ===== test/quoted_escape_encoder_tb.sv =====
// Top of the quoted escape encoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module quoted_escape_encoder_tb;

  // The random part stops once this many words have gone in after the directed ones.
  localparam int unsigned RANDOM_WORDS    = 240;
  localparam int unsigned DIRECTED_WORDS  = 20;
  // A word produces at most six characters, so this quiet wait after the scoreboard
  // empties is plenty to catch any stray output.
  localparam int unsigned DRAIN_CYCLES    = 24;
  // Long enough for the input register and the run buffer to fill up.
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned PRESSURE_WORDS  = 24;

  logic       clk             = 1'b0;
  logic       rst             = 1'b1;
  logic       byte_valid      = 1'b0;
  logic [7:0] byte_value      = 8'h00;
  logic       first_of_string = 1'b0;
  logic       last_of_string  = 1'b0;
  logic       empty_string    = 1'b0;
  logic       char_stall      = 1'b0;
  logic       byte_stall;
  logic       char_valid;
  logic [7:0] out_char;
  logic       end_of_run;
  logic       end_of_text;

  int unsigned pending;
  int unsigned fail_count;

  // Idle rates in percent for the two sides; the stimulus changes them per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned words_sent    = 0;

  // The stimulus bumps hold_starts to ask for a long hold-off; the receiver
  // process notices the change and counts the stall cycles on its own.
  int unsigned hold_starts = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;

  always #4 clk = ~clk;

  quoted_escape_encoder u_top (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .byte_value      (byte_value),
    .first_of_string (first_of_string),
    .last_of_string  (last_of_string),
    .empty_string    (empty_string),
    .char_valid      (char_valid),
    .char_stall      (char_stall),
    .out_char        (out_char),
    .end_of_run      (end_of_run),
    .end_of_text     (end_of_text)
  );

  quoted_escape_encoder_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .byte_value      (byte_value),
    .first_of_string (first_of_string),
    .last_of_string  (last_of_string),
    .empty_string    (empty_string),
    .char_valid      (char_valid),
    .char_stall      (char_stall),
    .out_char        (out_char),
    .end_of_run      (end_of_run),
    .end_of_text     (end_of_text),
    .pending         (pending),
    .fail_count      (fail_count)
  );

  // Receiver side. A pending hold-off request wins over the random stalls,
  // so the block sees an unbroken run of stall cycles while it fills up.
  always @(negedge clk) begin
    if (hold_starts != hold_seen) begin
      hold_seen <= hold_starts;
      hold_left <= HOLD_OFF_CYCLES - 1;
      char_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      char_stall <= 1'b1;
    end else begin
      char_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic qee_pkg::item_t word_of(input logic [7:0] b, input logic first,
                                             input logic last, input logic empty);
    qee_pkg::item_t w;
    w.byte_value      = b;
    w.first_of_string = first;
    w.last_of_string  = last;
    w.empty_string    = empty;
    return w;
  endfunction

  // Bytes are drawn so that escapes, plain printable text and hex escapes
  // all show up often; a quarter of them come from the two-character set.
  function automatic logic [7:0] random_byte();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(6))
          0: return qee_pkg::CH_BSLASH;
          1: return qee_pkg::CH_QUOTE;
          2: return qee_pkg::CH_LF;
          3: return qee_pkg::CH_CR;
          4: return qee_pkg::CH_TAB;
          5: return qee_pkg::CH_BEL;
          default: return qee_pkg::CH_BS;
        endcase
      end
      1: return 8'($urandom_range(qee_pkg::CH_SPACE, qee_pkg::CH_TILDE));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Offers one word and returns right after the rising edge that accepts it.
  // Valid is only ever assigned once per falling edge, and the payload stays
  // put for as long as the block stalls it.
  task automatic send_word(input qee_pkg::item_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      // Junk on an idle bus must not be taken as a word.
      {empty_string, first_of_string, last_of_string, byte_value} <= 11'($urandom);
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    {empty_string, first_of_string, last_of_string, byte_value} <= w;
    do begin
      @(posedge clk);
    end while (byte_stall);
    words_sent++;
  endtask

  // A well-formed string of len bytes; a zero length becomes the empty-string
  // word, with the ignored fields filled at random.
  task automatic send_string(input int unsigned len);
    if (len == 0) begin
      send_word(word_of(8'($urandom), 1'($urandom), 1'($urandom), 1'b1));
    end else begin
      for (int unsigned i = 0; i < len; i++) begin
        send_word(word_of(random_byte(), i == 0, i == len - 1, 1'b0));
      end
    end
  endtask

  // Mostly proper strings, with some fully random words mixed in to cover
  // broken framing such as stray middles and repeated first flags.
  task automatic send_random_until(input int unsigned target);
    while (words_sent < target) begin
      if ($urandom_range(99) < 15) begin
        send_word(word_of(8'($urandom), 1'($urandom), 1'($urandom),
                          $urandom_range(7) == 0));
      end else begin
        send_string($urandom_range(6));
      end
    end
  endtask

  // Drops valid and waits for the scoreboard to run dry.
  task automatic wait_drained();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // First phase: the sender idles now and then, the receiver mostly stalls.
    send_idle_pct = 37;
    recv_idle_pct = 70;

    // Empty strings, once with every ignored field set and once with none.
    send_word(word_of(8'hFF, 1'b1, 1'b1, 1'b1));
    send_word(word_of(8'h00, 1'b0, 1'b0, 1'b1));
    // A one-byte string carries both quotes around a plain letter.
    send_word(word_of(8'h41, 1'b1, 1'b1, 1'b0));
    // Every two-character escape, closed by a NUL that needs a hex escape.
    send_word(word_of(qee_pkg::CH_QUOTE,  1'b1, 1'b0, 1'b0));
    send_word(word_of(qee_pkg::CH_BSLASH, 1'b0, 1'b0, 1'b0));
    send_word(word_of(qee_pkg::CH_LF,     1'b0, 1'b0, 1'b0));
    send_word(word_of(qee_pkg::CH_CR,     1'b0, 1'b0, 1'b0));
    send_word(word_of(qee_pkg::CH_TAB,    1'b0, 1'b0, 1'b0));
    send_word(word_of(qee_pkg::CH_BEL,    1'b0, 1'b0, 1'b0));
    send_word(word_of(qee_pkg::CH_BS,     1'b0, 1'b0, 1'b0));
    send_word(word_of(8'h00,              1'b0, 1'b1, 1'b0));
    // Both edges of the printable range and the bytes just outside it.
    send_word(word_of(8'h1F, 1'b1, 1'b0, 1'b0));
    send_word(word_of(8'h20, 1'b0, 1'b0, 1'b0));
    send_word(word_of(8'h7E, 1'b0, 1'b0, 1'b0));
    send_word(word_of(8'h7F, 1'b0, 1'b0, 1'b0));
    send_word(word_of(8'h80, 1'b0, 1'b0, 1'b0));
    send_word(word_of(8'hFF, 1'b0, 1'b1, 1'b0));
    // The block keeps no framing state: a bare byte after a closed string,
    // then two opening flags in a row, are encoded exactly as flagged.
    send_word(word_of(8'h61, 1'b0, 1'b0, 1'b0));
    send_word(word_of(8'h62, 1'b1, 1'b0, 1'b0));
    send_word(word_of(8'h63, 1'b1, 1'b1, 1'b0));

    send_random_until(DIRECTED_WORDS + RANDOM_WORDS / 3);

    // The sender pauses here until every expected character has come out.
    wait_drained();

    // Second phase: the roles swap, so the block mostly runs starved.
    send_idle_pct = 70;
    recv_idle_pct = 37;
    send_random_until(DIRECTED_WORDS + 2 * RANDOM_WORDS / 3);
    wait_drained();

    // Third phase: no idling at all. It opens with a long receiver hold-off
    // while the sender keeps offering words, so byte_stall has to rise.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_starts++;
    send_random_until(words_sent + PRESSURE_WORDS);
    send_random_until(DIRECTED_WORDS + RANDOM_WORDS);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("quoted_escape_encoder_tb: clean");
    end else begin
      $display("quoted_escape_encoder_tb: errors");
    end
    $finish;
  end

  // Safety net in case the block hangs; far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("quoted_escape_encoder_tb: errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/qee_pkg.sv
design/qee_decode.sv
design/qee_serializer.sv
design/quoted_escape_encoder.sv
test/quoted_escape_encoder_checker.sv
test/quoted_escape_encoder_tb.sv
